/* hw/rtl/quaternion_rotate_vector_macros.svh */
// Assertion helpers for the verification file of the rotation block.
// Each macro uses the clock clk and the reset rst of the module it sits in.
`ifndef QUATERNION_ROTATE_VECTOR_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QRV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Checked also while reset is applied.
`define QRV_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("reset check failed");

`endif

/* hw/rtl/qrv_pkg.sv */
package qrv_pkg;

  // One 32-bit signed field, Q2.30 for the quaternion and Q16.16 for vectors.
  typedef logic signed [31:0] word_t;

  // Clipping limits of a Q16.16 result.
  localparam word_t SAT_MAX = 32'sh7FFF_FFFF;
  localparam word_t SAT_MIN = 32'sh8000_0000;

  // Widths inside the datapath.
  localparam int COEF_W    = 66;  // rotation matrix entry, Q6.60
  localparam int SPLIT     = 33;  // low part of an entry for the multipliers
  localparam int LO_W      = 66;  // low partial product
  localparam int HI_W      = 65;  // high partial product
  localparam int LOSUM_W   = 68;  // sum of three low partial products
  localparam int HISUM_W   = 67;  // sum of three high partial products
  localparam int ACC_W     = 100; // full dot product, 76 fraction bits
  localparam int FRAC_DROP = 60;  // fraction bits dropped by rounding
  localparam int R_W       = ACC_W - FRAC_DROP;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [LO_W-1:0]    lo_t;
  typedef logic signed [HI_W-1:0]    hi_t;
  typedef logic signed [LOSUM_W-1:0] losum_t;
  typedef logic signed [HISUM_W-1:0] hisum_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [R_W-1:0]     rnd_t;

  // One half of the kept least significant bit, for round to nearest.
  localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_DROP - 1);

endpackage

/* hw/rtl/quaternion_rotate_vector.sv */
// Throughput: one rotation per clock cycle while the output is not stalled.
// The rate is set by the six register stages, which all advance together.
// Reset (rst, synchronous, active high) clears every stage valid bit;
// the payload registers are not reset.
module quaternion_rotate_vector (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  qrv_pkg::word_t quat_x,
  input  qrv_pkg::word_t quat_y,
  input  qrv_pkg::word_t quat_z,
  input  qrv_pkg::word_t quat_w,
  input  qrv_pkg::word_t vec_x,
  input  qrv_pkg::word_t vec_y,
  input  qrv_pkg::word_t vec_z,
  output logic           out_valid,
  input  logic           out_stall,
  output qrv_pkg::word_t rot_x,
  output qrv_pkg::word_t rot_y,
  output qrv_pkg::word_t rot_z,
  output logic           saturated
);
  import qrv_pkg::*;

  // The pipeline moves as one unit. It only holds when the output register
  // carries a result that the downstream side refuses; then every stage keeps
  // its contents, so nothing is dropped or duplicated. Empty stages are
  // simply carried along as bubbles with their valid bit low.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: the ten quaternion products, each a 32 by 32 multiply.
  logic  s1_valid;
  logic signed [63:0] s1_xx, s1_yy, s1_zz, s1_ww;
  logic signed [63:0] s1_xy, s1_xz, s1_yz, s1_wx, s1_wy, s1_wz;
  word_t s1_v [3];

  // Stage 2: the nine entries of the (unnormalized) rotation matrix.
  logic  s2_valid;
  coef_t s2_c [3][3];
  word_t s2_v [3];
  coef_t c_next [3][3];

  // Stage 3: each matrix entry times a vector component, split into a low
  // unsigned half and a high signed half so no multiplier exceeds 34 by 32.
  logic s3_valid;
  lo_t  s3_lo [3][3];
  hi_t  s3_hi [3][3];

  // Stage 4: the three terms of each output summed, halves kept apart.
  logic   s4_valid;
  losum_t s4_lo [3];
  hisum_t s4_hi [3];

  // Stage 5: halves joined, rounded, and the fraction dropped.
  logic s5_valid;
  rnd_t s5_r [3];
  acc_t acc_next [3];

  // Stage 6 is the output register itself.
  word_t rot_next [3];
  logic  sat_next;

  // Matrix entries from the products. Rows select the output axis and
  // columns the vector component. Off-diagonal entries carry the factor two.
  always_comb begin
    c_next[0][0] = coef_t'(s1_ww) + coef_t'(s1_xx) - coef_t'(s1_yy) - coef_t'(s1_zz);
    c_next[0][1] = (coef_t'(s1_xy) - coef_t'(s1_wz)) <<< 1;
    c_next[0][2] = (coef_t'(s1_xz) + coef_t'(s1_wy)) <<< 1;
    c_next[1][0] = (coef_t'(s1_xy) + coef_t'(s1_wz)) <<< 1;
    c_next[1][1] = coef_t'(s1_ww) - coef_t'(s1_xx) + coef_t'(s1_yy) - coef_t'(s1_zz);
    c_next[1][2] = (coef_t'(s1_yz) - coef_t'(s1_wx)) <<< 1;
    c_next[2][0] = (coef_t'(s1_xz) - coef_t'(s1_wy)) <<< 1;
    c_next[2][1] = (coef_t'(s1_yz) + coef_t'(s1_wx)) <<< 1;
    c_next[2][2] = coef_t'(s1_ww) - coef_t'(s1_xx) - coef_t'(s1_yy) + coef_t'(s1_zz);
  end

  // The full sum has 76 fraction bits and stays well inside the accumulator
  // width, so the arithmetic shift after adding one half rounds to nearest
  // with ties going toward plus infinity.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_next[i] = (acc_t'(s4_hi[i]) <<< SPLIT) + acc_t'(s4_lo[i]) + ROUND_HALF;
    end
  end

  // Clip each rounded component to the Q16.16 range and flag any clipping.
  always_comb begin
    sat_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s5_r[i] > rnd_t'(SAT_MAX)) begin
        rot_next[i] = SAT_MAX;
        sat_next    = 1'b1;
      end else if (s5_r[i] < rnd_t'(SAT_MIN)) begin
        rot_next[i] = SAT_MIN;
        sat_next    = 1'b1;
      end else begin
        rot_next[i] = s5_r[i][31:0];
      end
    end
  end

  // Valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
  end

  // Datapath registers, loaded whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xx   <= quat_x * quat_x;
      s1_yy   <= quat_y * quat_y;
      s1_zz   <= quat_z * quat_z;
      s1_ww   <= quat_w * quat_w;
      s1_xy   <= quat_x * quat_y;
      s1_xz   <= quat_x * quat_z;
      s1_yz   <= quat_y * quat_z;
      s1_wx   <= quat_w * quat_x;
      s1_wy   <= quat_w * quat_y;
      s1_wz   <= quat_w * quat_z;
      s1_v[0] <= vec_x;
      s1_v[1] <= vec_y;
      s1_v[2] <= vec_z;

      for (int i = 0; i < 3; i++) begin
        s2_v[i] <= s1_v[i];
        for (int j = 0; j < 3; j++) begin
          s2_c[i][j] <= c_next[i][j];
        end
      end

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s3_lo[i][j] <= $signed({1'b0, s2_c[i][j][SPLIT-1:0]}) * s2_v[j];
          s3_hi[i][j] <= $signed(s2_c[i][j][COEF_W-1:SPLIT]) * s2_v[j];
        end
      end

      for (int i = 0; i < 3; i++) begin
        s4_lo[i] <= losum_t'(s3_lo[i][0]) + losum_t'(s3_lo[i][1]) + losum_t'(s3_lo[i][2]);
        s4_hi[i] <= hisum_t'(s3_hi[i][0]) + hisum_t'(s3_hi[i][1]) + hisum_t'(s3_hi[i][2]);
      end

      for (int i = 0; i < 3; i++) begin
        s5_r[i] <= acc_next[i][ACC_W-1:FRAC_DROP];
      end

      rot_x     <= rot_next[0];
      rot_y     <= rot_next[1];
      rot_z     <= rot_next[2];
      saturated <= sat_next;
    end
  end

endmodule

/* hw/rtl/qrv_checker.sv */
`include "quaternion_rotate_vector_macros.svh"

module qrv_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input qrv_pkg::word_t rot_x,
  input qrv_pkg::word_t rot_y,
  input qrv_pkg::word_t rot_z,
  input logic           saturated
);
  import qrv_pkg::*;

  // A refused result stays in place unchanged.
  `QRV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(rot_x) && $stable(rot_y) && $stable(rot_z) && $stable(saturated))

  // The input side only stalls when a result is waiting on a stalled output.
  `QRV_ASSERT_SAME(a_in_stall_cause, in_stall || (in_valid && in_stall), out_valid && out_stall)

  // A flagged result has at least one component at a clipping limit.
  `QRV_ASSERT_SAME(a_sat_clip, out_valid && saturated, rot_x == SAT_MAX || rot_x == SAT_MIN || rot_y == SAT_MAX || rot_y == SAT_MIN || rot_z == SAT_MAX || rot_z == SAT_MIN)

  // The pipeline is empty right after reset.
  `QRV_ASSERT_ALWAYS(a_reset_empty, $past(rst), !out_valid && !in_stall)

endmodule

bind quaternion_rotate_vector qrv_checker u_qrv_checker (.*);
